### design/ddr_pkg.sv
// shared types, constants and fixed-point helpers for the diff-drive ramp block
// no dependencies
`timescale 1ns / 1ps
package ddr_pkg;

	localparam logic [31:0] RPM_PER_RAD   = 32'd625823;
	localparam logic [5:0]  RATE_DIV_LAST = 6'd47;
	localparam logic [5:0]  PWM_DIV_LAST  = 6'd31;

	localparam logic [31:0] RST_WHEEL_RADIUS = 32'd3277;
	localparam logic [31:0] RST_WHEEL_BASE   = 32'd24904;
	localparam logic [31:0] RST_GEAR_RATIO   = 32'd4666163;
	localparam logic [15:0] RST_MOTOR_MAX    = 16'd10000;
	localparam logic [15:0] RST_PWM_FULL     = 16'd255;
	localparam logic [31:0] RST_ACCEL_TIME   = 32'd65536;
	localparam logic [31:0] RST_DECEL_TIME   = 32'd32768;

	localparam logic signed [49:0] MAX32 = 50'sd2147483647;
	localparam logic signed [49:0] MIN32 = -50'sd2147483648;
	localparam logic signed [49:0] MAX16 = 50'sd32767;
	localparam logic signed [49:0] MIN16 = -50'sd32768;

	typedef enum logic [2:0] {
		CFG_WHEEL_RADIUS = 3'd0,
		CFG_WHEEL_BASE   = 3'd1,
		CFG_GEAR_RATIO   = 3'd2,
		CFG_MOTOR_MAX    = 3'd3,
		CFG_PWM_FULL     = 3'd4,
		CFG_ACCEL_TIME   = 3'd5,
		CFG_DECEL_TIME   = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECIDE,
		OP_DIV_STEP,
		OP_RATE,
		OP_SPEED_MUL,
		OP_SPEED_SET,
		OP_BW_MUL,
		OP_BW_SET,
		OP_WHEEL_LOAD,
		OP_RPM_MUL,
		OP_GEAR_MUL,
		OP_PWM_MUL,
		OP_PWM_LOAD,
		OP_PWM_SET,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECIDE,
		S_RATE_DIV,
		S_RATE_SET,
		S_SPEED_MUL,
		S_SPEED_SET,
		S_BW_MUL,
		S_BW_SET,
		S_WHEEL_LOAD,
		S_WHEEL_DIV,
		S_RPM_MUL,
		S_GEAR_MUL,
		S_PWM_MUL,
		S_PWM_LOAD,
		S_PWM_DIV,
		S_PWM_SET,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		BR_HOLD,
		BR_ACCEL,
		BR_DECEL
	} branch_t;

	typedef struct packed {
		op_t  op;
		logic wheel;
	} cmd_t;

	typedef struct packed {
		logic latch;
	} sts_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	function automatic logic signed [49:0] apply_sign(input logic neg, input logic [47:0] m);
		logic signed [49:0] s;
		s = $signed({2'b00, m});
		return neg ? -s : s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		if (x > MAX32) return 32'sh7FFFFFFF;
		else if (x < MIN32) return 32'sh80000000;
		else return x[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
		if (x > MAX16) return 16'sh7FFF;
		else if (x < MIN16) return 16'sh8000;
		else return x[15:0];
	endfunction

endpackage

### design/ddr_if.sv
// valid/ready channel interfaces: command items, drive result items, register writes
// no dependencies
`timescale 1ns / 1ps
interface ddr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_linear;
	logic signed [31:0] angular_rate;
	logic        [31:0] elapsed_time;
	modport source (output valid, target_linear, angular_rate, elapsed_time, input ready);
	modport sink (input valid, target_linear, angular_rate, elapsed_time, output ready);
endinterface

interface ddr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic signed [31:0] ramped_speed;
	modport source (output valid, left_drive, right_drive, ramped_speed, input ready);
	modport sink (input valid, left_drive, right_drive, ramped_speed, output ready);
endinterface

interface ddr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/ddr_ctrl.sv
// sequencer: steps the datapath through ramp, kinematics and pwm for one item
// depends on ddr_pkg
`timescale 1ns / 1ps
module ddr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ddr_pkg::sts_t sts,
	output ddr_pkg::cmd_t cmd
);
	import ddr_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       wheel_q, wheel_d;
	logic       out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			wheel_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			wheel_q     <= wheel_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		wheel_d     = wheel_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.wheel   = wheel_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op  = OP_DECIDE;
				cnt_d   = RATE_DIV_LAST;
				state_d = sts.latch ? S_RATE_DIV : S_SPEED_MUL;
			end
			S_RATE_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q - 6'd1;
				if (cnt_q == '0) state_d = S_RATE_SET;
			end
			S_RATE_SET: begin
				cmd.op  = OP_RATE;
				state_d = S_SPEED_MUL;
			end
			S_SPEED_MUL: begin
				cmd.op  = OP_SPEED_MUL;
				state_d = S_SPEED_SET;
			end
			S_SPEED_SET: begin
				cmd.op  = OP_SPEED_SET;
				state_d = S_BW_MUL;
			end
			S_BW_MUL: begin
				cmd.op  = OP_BW_MUL;
				state_d = S_BW_SET;
			end
			S_BW_SET: begin
				cmd.op  = OP_BW_SET;
				wheel_d = 1'b0;
				state_d = S_WHEEL_LOAD;
			end
			S_WHEEL_LOAD: begin
				cmd.op  = OP_WHEEL_LOAD;
				cnt_d   = RATE_DIV_LAST;
				state_d = S_WHEEL_DIV;
			end
			S_WHEEL_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q - 6'd1;
				if (cnt_q == '0) state_d = S_RPM_MUL;
			end
			S_RPM_MUL: begin
				cmd.op  = OP_RPM_MUL;
				state_d = S_GEAR_MUL;
			end
			S_GEAR_MUL: begin
				cmd.op  = OP_GEAR_MUL;
				state_d = S_PWM_MUL;
			end
			S_PWM_MUL: begin
				cmd.op  = OP_PWM_MUL;
				state_d = S_PWM_LOAD;
			end
			S_PWM_LOAD: begin
				cmd.op  = OP_PWM_LOAD;
				cnt_d   = PWM_DIV_LAST;
				state_d = S_PWM_DIV;
			end
			S_PWM_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q - 6'd1;
				if (cnt_q == '0) state_d = S_PWM_SET;
			end
			S_PWM_SET: begin
				cmd.op = OP_PWM_SET;
				if (wheel_q) begin
					state_d = S_OUT;
				end else begin
					wheel_d = 1'b1;
					state_d = S_WHEEL_LOAD;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### design/ddr_dpath.sv
// datapath: register file, ramp state, shared 32x32 multiplier, bit-serial divider
// depends on ddr_pkg
`timescale 1ns / 1ps
module ddr_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  ddr_pkg::cmd_t      cmd,
	output ddr_pkg::sts_t      sts,
	input  logic signed [31:0] target_linear,
	input  logic signed [31:0] angular_rate,
	input  logic        [31:0] elapsed_time,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	output logic signed [31:0] ramped_speed
);
	import ddr_pkg::*;

	// configuration
	logic [31:0] radius_q, base_q, gear_q, atime_q, dtime_q;
	logic [15:0] mmax_q, pfull_q;

	// item and ramp state
	logic signed [31:0] tgt_q, turn_q;
	logic        [31:0] dt_q;
	logic signed [31:0] v_q, arate_q, drate_q;
	logic        [31:0] elapsed_q;
	logic        [1:0]  acnt_q, dcnt_q;
	branch_t            br_q;

	// work registers
	logic        [63:0] p_q;
	logic               neg_q;
	logic signed [47:0] bw_q;
	logic        [31:0] rem_q, dvs_q;
	logic        [47:0] dvd_q, quo_q;
	logic signed [15:0] lres_q, rres_q;
	logic signed [15:0] left_q, right_q;
	logic signed [31:0] ramped_q;

	// decide logic
	branch_t     br_now;
	logic        latch;
	logic [1:0]  cnt_old, cnt_new;
	logic [31:0] ramp_t, base_el, el_new;
	logic [32:0] sum33;

	always_comb begin
		if (v_q != tgt_q) br_now = (tgt_q == '0) ? BR_DECEL : BR_ACCEL;
		else br_now = BR_HOLD;
		cnt_old = (br_now == BR_ACCEL) ? acnt_q : dcnt_q;
		latch   = (br_now != BR_HOLD) && (cnt_old < 2'd2);
		cnt_new = latch ? cnt_old + 2'd1 : cnt_old;
		ramp_t  = (br_now == BR_ACCEL) ? atime_q : dtime_q;
		base_el = latch ? '0 : elapsed_q;
		sum33   = {1'b0, base_el} + ((cnt_new > 2'd1) ? {1'b0, dt_q} : 33'd0);
		el_new  = (sum33 > {1'b0, ramp_t}) ? ramp_t : sum33[31:0];
	end

	assign sts.latch = latch;

	// wheel half-track term and the values passed between multiply steps
	logic signed [49:0] h_w;
	logic signed [31:0] h_sat, q_sat, rpm_sat, ramp_rate;
	logic signed [15:0] motor_sat, pwm_res;
	logic signed [49:0] lneg;

	always_comb begin
		h_w = cmd.wheel ? $signed({{18{v_q[31]}}, v_q}) + $signed({{2{bw_q[47]}}, bw_q})
		                : $signed({{18{v_q[31]}}, v_q}) - $signed({{2{bw_q[47]}}, bw_q});
		h_sat     = sat32(h_w);
		q_sat     = sat32(apply_sign(neg_q, quo_q));
		rpm_sat   = sat32(apply_sign(neg_q, p_q[63:16]));
		motor_sat = sat16(apply_sign(neg_q, {16'b0, p_q[63:32]}));
		pwm_res   = sat16(apply_sign(neg_q, quo_q));
		lneg      = -$signed({{34{pwm_res[15]}}, pwm_res});
		ramp_rate = (br_q == BR_ACCEL) ? arate_q : drate_q;
	end

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SPEED_MUL: begin
				mul_a = mag32(ramp_rate);
				mul_b = (br_q == BR_ACCEL) ? elapsed_q : dtime_q - elapsed_q;
			end
			OP_BW_MUL: begin
				mul_a = mag32(turn_q);
				mul_b = base_q;
			end
			OP_RPM_MUL: begin
				mul_a = mag32(q_sat);
				mul_b = RPM_PER_RAD;
			end
			OP_GEAR_MUL: begin
				mul_a = mag32(rpm_sat);
				mul_b = gear_q;
			end
			OP_PWM_MUL: begin
				mul_a = mag32(32'(motor_sat));
				mul_b = {16'b0, pfull_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	// divider step
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, dvd_q[47]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RST_WHEEL_RADIUS;
			base_q   <= RST_WHEEL_BASE;
			gear_q   <= RST_GEAR_RATIO;
			mmax_q   <= RST_MOTOR_MAX;
			pfull_q  <= RST_PWM_FULL;
			atime_q  <= RST_ACCEL_TIME;
			dtime_q  <= RST_DECEL_TIME;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WHEEL_RADIUS: radius_q <= cfg_data;
				CFG_WHEEL_BASE:   base_q   <= cfg_data;
				CFG_GEAR_RATIO:   gear_q   <= cfg_data;
				CFG_MOTOR_MAX:    mmax_q   <= cfg_data[15:0];
				CFG_PWM_FULL:     pfull_q  <= cfg_data[15:0];
				CFG_ACCEL_TIME:   atime_q  <= cfg_data;
				CFG_DECEL_TIME:   dtime_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			arate_q   <= '0;
			drate_q   <= '0;
			elapsed_q <= '0;
			acnt_q    <= '0;
			dcnt_q    <= '0;
			br_q      <= BR_HOLD;
		end else begin
			case (cmd.op)
				OP_DECIDE: begin
					br_q <= br_now;
					unique case (br_now)
						BR_ACCEL: begin
							dcnt_q    <= '0;
							acnt_q    <= cnt_new;
							elapsed_q <= el_new;
						end
						BR_DECEL: begin
							acnt_q    <= '0;
							dcnt_q    <= cnt_new;
							elapsed_q <= el_new;
						end
						default: begin
							acnt_q    <= '0;
							dcnt_q    <= '0;
							elapsed_q <= '0;
						end
					endcase
				end
				OP_RATE: begin
					if (br_q == BR_ACCEL) arate_q <= q_sat;
					else drate_q <= q_sat;
				end
				OP_SPEED_SET: begin
					if (br_q != BR_HOLD) v_q <= sat32(apply_sign(neg_q, p_q[63:16]));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				tgt_q  <= target_linear;
				turn_q <= angular_rate;
				dt_q   <= elapsed_time;
			end
			OP_DECIDE: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= {mag32((br_now == BR_ACCEL) ? tgt_q : v_q), 16'b0};
				dvs_q <= (ramp_t == '0) ? 32'd1 : ramp_t;
				neg_q <= (br_now == BR_ACCEL) ? tgt_q[31] : v_q[31];
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
				dvd_q <= {dvd_q[46:0], 1'b0};
				quo_q <= {quo_q[46:0], ge};
			end
			OP_SPEED_MUL: begin
				p_q   <= prod;
				neg_q <= ramp_rate[31];
			end
			OP_BW_MUL: begin
				p_q   <= prod;
				neg_q <= turn_q[31];
			end
			OP_BW_SET: begin
				bw_q <= 48'(apply_sign(neg_q, {1'b0, p_q[63:17]}));
			end
			OP_WHEEL_LOAD: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= {mag32(h_sat), 16'b0};
				dvs_q <= (radius_q == '0) ? 32'd1 : radius_q;
				neg_q <= h_sat[31];
			end
			OP_RPM_MUL: begin
				p_q   <= prod;
				neg_q <= q_sat[31];
			end
			OP_GEAR_MUL: begin
				p_q   <= prod;
				neg_q <= rpm_sat[31];
			end
			OP_PWM_MUL: begin
				p_q   <= prod;
				neg_q <= motor_sat[15];
			end
			OP_PWM_LOAD: begin
				rem_q <= '0;
				quo_q <= '0;
				dvd_q <= {p_q[31:0], 16'b0};
				dvs_q <= {16'b0, (mmax_q == '0) ? 16'd1 : mmax_q};
			end
			OP_PWM_SET: begin
				if (cmd.wheel) rres_q <= pwm_res;
				else lres_q <= sat16(lneg);
			end
			OP_OUT: begin
				left_q   <= lres_q;
				right_q  <= rres_q;
				ramped_q <= v_q;
			end
			default: ;
		endcase
	end

	assign left_drive   = left_q;
	assign right_drive  = right_q;
	assign ramped_speed = ramped_q;

endmodule

### design/diff_drive_ramp_to_pwm_top.sv
// top level: speed ramp and differential-drive inverse kinematics to wheel pwm
// depends on ddr_pkg, ddr_if, ddr_ctrl, ddr_dpath
//
//  channel  dir  payload                                       handshake
//  in_ch    in   target_linear, angular_rate, elapsed_time      valid/ready
//  out_ch   out  left_drive, right_drive, ramped_speed          valid/ready
//  cfg      in   index (3b), data (32b)                         valid/ready, ready always high
//
// one item at a time; the divider gives one quotient bit per cycle, in two 48-step and
// two 32-step passes per item, plus one 48-step pass for the rate when it is latched.
// the result register lets the next item enter while the previous result waits; a
// stalled output holds the block before the result write. reset restores the register
// defaults and clears the ramp.
`timescale 1ns / 1ps
module diff_drive_ramp_to_pwm_top (
	input logic        clk,
	input logic        arst_n,
	ddr_in_if.sink     in_ch,
	ddr_out_if.source  out_ch,
	ddr_cfg_if.sink    cfg
);
	import ddr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	ddr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ddr_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.target_linear (in_ch.target_linear),
		.angular_rate  (in_ch.angular_rate),
		.elapsed_time  (in_ch.elapsed_time),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.left_drive    (out_ch.left_drive),
		.right_drive   (out_ch.right_drive),
		.ramped_speed  (out_ch.ramped_speed)
	);

`ifndef SYNTHESIS
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("item accepted while previous item still in work");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !$rose(out_ch.valid))
		else $error("result raised right after accepting an item");

	a_div_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIV_STEP) |-> !in_ch.ready)
		else $error("divider stepping while input side is open");
`endif

endmodule

### dv/tb_diff_drive_ramp_to_pwm_top.sv
// testbench for diff_drive_ramp_to_pwm_top: random and directed ramp commands through the pipeline,
// checked item by item against a built-in predictor of the ramp and wheel pwm math
// depends on ddr_pkg, ddr_if and the design files under design/
`timescale 1ns / 1ps
module tb_diff_drive_ramp_to_pwm_top;
	import ddr_pkg::*;

	typedef struct {
		logic signed [31:0] target;
		logic signed [31:0] turn;
		logic        [31:0] dt;
	} cmd_item_t;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [31:0] speed;
	} drive_t;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int     SETTLE = 300;

	logic clk;
	logic arst_n;
	ddr_in_if  in_if();
	ddr_out_if out_if();
	ddr_cfg_if cfg_if();

	diff_drive_ramp_to_pwm_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if), .cfg(cfg_if)
	);

	cmd_item_t cmd_q[$];
	drive_t    drive_q[$];
	int        errors;
	int        n_sent;
	int        n_checked;
	int        gap_max;
	int        stall_max;
	longint    cycles;

	// register shadows
	longint unsigned r_radius, r_base, r_gear, r_mmax, r_pwm, r_accel, r_decel;
	// ramp state
	longint          spd;
	longint unsigned ramp_el;
	longint          arate, drate;
	int              acnt, dcnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned magn(longint a);
		return a < 0 ? longint'(-a) : longint'(a);
	endfunction

	function automatic longint clamp(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint s32(longint x);
		return clamp(x, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint s16(longint x);
		return clamp(x, -64'sd32768, 64'sd32767);
	endfunction

	function automatic longint mul_trunc(longint a, longint unsigned b, int sh);
		longint unsigned p;
		p = (magn(a) * b) >> sh;
		return a < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint div_q16(longint a, longint unsigned d);
		longint unsigned q;
		if (d == 0) d = 1;
		q = (magn(a) << 16) / d;
		return a < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint wheel_pwm(longint h);
		longint unsigned ms, p;
		longint rate, rpm, motor;
		ms = r_mmax != 0 ? r_mmax : 1;
		rate = s32(div_q16(s32(h), r_radius));
		rpm = s32(mul_trunc(rate, 625823, 16));
		motor = s16(mul_trunc(rpm, r_gear, 32));
		p = (magn(motor) * r_pwm) / ms;
		return s16(motor < 0 ? -longint'(p) : longint'(p));
	endfunction

	function automatic drive_t predict_drive(cmd_item_t c);
		longint tgt, trn, v, bw, l, r;
		longint unsigned dt;
		drive_t d;
		tgt = longint'(c.target);
		trn = longint'(c.turn);
		dt = {32'd0, c.dt};
		v = spd;
		if (v != tgt && tgt != 0) begin
			dcnt = 0;
			if (acnt < 2) begin
				ramp_el = 0;
				arate = s32(div_q16(tgt, r_accel));
				acnt++;
			end
			if (acnt > 1) ramp_el += dt;
			if (ramp_el > r_accel) ramp_el = r_accel;
			v = s32(mul_trunc(arate, ramp_el, 16));
		end else if (v != tgt) begin
			acnt = 0;
			if (dcnt < 2) begin
				ramp_el = 0;
				drate = s32(div_q16(v, r_decel));
				dcnt++;
			end
			if (dcnt > 1) ramp_el += dt;
			if (ramp_el > r_decel) begin
				ramp_el = r_decel;
				v = 0;
			end else begin
				v = s32(mul_trunc(drate, r_decel - ramp_el, 16));
			end
		end else begin
			ramp_el = 0;
			acnt = 0;
			dcnt = 0;
		end
		spd = v;
		bw = mul_trunc(trn, r_base, 17);
		l = wheel_pwm(v - bw);
		r = wheel_pwm(v + bw);
		d.left = 16'(s16(-l));
		d.right = 16'(r);
		d.speed = 32'(v);
		return d;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch %0s at result %0d: got %0d expected %0d", field, n_checked, got, want);
	endtask

	// command driver
	int gap_cnt;
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t c;
		logic nv;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			gap_cnt = 0;
		end else begin
			nv = in_if.valid;
			if (in_if.valid && in_if.ready) begin
				drive_q.insert(drive_q.size(), predict_drive('{in_if.target_linear,
					in_if.angular_rate, in_if.elapsed_time}));
				n_sent++;
			end
			if (!in_if.valid || in_if.ready) begin
				nv = 1'b0;
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (cmd_q.size() > 0) begin
					c = cmd_q.pop_front();
					in_if.target_linear <= c.target;
					in_if.angular_rate <= c.turn;
					in_if.elapsed_time <= c.dt;
					nv = 1'b1;
					gap_cnt = $urandom_range(0, gap_max);
				end
			end
			in_if.valid <= nv;
		end
	end

	// result monitor
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (drive_q.size() == 0) begin
					errors++;
					$display("unexpected result with nothing pending");
				end else begin
					want = drive_q.pop_front();
					if (out_if.left_drive !== want.left)
						report_mismatch("left_drive", out_if.left_drive, want.left);
					if (out_if.right_drive !== want.right)
						report_mismatch("right_drive", out_if.right_drive, want.right);
					if (out_if.ramped_speed !== want.speed)
						report_mismatch("ramped_speed", out_if.ramped_speed, want.speed);
				end
				n_checked++;
				stall_cnt = $urandom_range(0, stall_max);
			end else if (stall_cnt > 0) begin
				stall_cnt--;
			end
			out_if.ready <= (stall_cnt == 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, drive_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_WHEEL_RADIUS: r_radius = val;
			CFG_WHEEL_BASE:   r_base = val;
			CFG_GEAR_RATIO:   r_gear = val;
			CFG_MOTOR_MAX:    r_mmax = val[15:0];
			CFG_PWM_FULL:     r_pwm = val[15:0];
			CFG_ACCEL_TIME:   r_accel = val;
			CFG_DECEL_TIME:   r_decel = val;
			default: ;
		endcase
	endtask

	task automatic cfg_all(logic [31:0] rad, logic [31:0] base, logic [31:0] gear,
			logic [31:0] mmax, logic [31:0] pwm, logic [31:0] acc, logic [31:0] dec);
		cfg_write(CFG_WHEEL_RADIUS, rad);
		cfg_write(CFG_WHEEL_BASE, base);
		cfg_write(CFG_GEAR_RATIO, gear);
		cfg_write(CFG_MOTOR_MAX, mmax);
		cfg_write(CFG_PWM_FULL, pwm);
		cfg_write(CFG_ACCEL_TIME, acc);
		cfg_write(CFG_DECEL_TIME, dec);
	endtask

	task automatic drain();
		while (cmd_q.size() > 0 || in_if.valid || drive_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_cmd(logic signed [31:0] t, logic signed [31:0] w, logic [31:0] dt);
		cmd_item_t c;
		c.target = t;
		c.turn = w;
		c.dt = dt;
		cmd_q.insert(cmd_q.size(), c);
	endtask

	function automatic logic signed [31:0] small_q16(int unsigned span);
		logic signed [31:0] x;
		x = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -x : x;
	endfunction

	task automatic gen_items(int n);
		int k, steps;
		logic signed [31:0] t;
		logic [31:0] dt_top;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 9) < 7) begin
				t = $urandom_range(0, 3) == 0 ? $urandom : small_q16(4 * 65536);
				if (t == 0) t = 32'sd65536;
				steps = $urandom_range(2, 10);
				if (steps > n - k) steps = n - k;
				dt_top = $urandom_range(0, 7) == 0 ? 32'hFFFF_FFFF : 32'd24000;
				repeat (steps) begin
					push_cmd(t, small_q16(3 * 65536), $urandom_range(0, dt_top));
					k++;
				end
				if ($urandom_range(0, 1)) begin
					steps = $urandom_range(2, 8);
					if (steps > n - k) steps = n - k;
					repeat (steps) begin
						push_cmd(0, small_q16(3 * 65536), $urandom_range(0, 20000));
						k++;
					end
				end
			end else begin
				push_cmd($urandom, $urandom, $urandom);
				k++;
			end
		end
	endtask

	initial begin
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		cycles = 0;
		gap_max = 18;
		stall_max = 18;
		r_radius = RST_WHEEL_RADIUS;
		r_base = RST_WHEEL_BASE;
		r_gear = RST_GEAR_RATIO;
		r_mmax = RST_MOTOR_MAX;
		r_pwm = RST_PWM_FULL;
		r_accel = RST_ACCEL_TIME;
		r_decel = RST_DECEL_TIME;
		spd = 0;
		ramp_el = 0;
		arate = 0;
		drate = 0;
		acnt = 0;
		dcnt = 0;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.target_linear = '0;
		in_if.angular_rate = '0;
		in_if.elapsed_time = '0;
		out_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_WHEEL_RADIUS;
		cfg_if.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hold at zero, ramp up and clamp, target change mid-ramp, decel, extremes
		push_cmd(0, 0, 0);
		push_cmd(32'sd65536, 0, 32'd16384);
		push_cmd(32'sd65536, 0, 32'd16384);
		push_cmd(32'sd65536, 32'sd65536, 32'd32768);
		push_cmd(32'sd131072, 0, 32'd16384);
		push_cmd(32'sd65536, 0, 32'd65536);
		push_cmd(32'sd65536, 0, 32'd100000);
		push_cmd(32'sd65536, 0, 32'd1000);
		push_cmd(0, 0, 32'd8000);
		push_cmd(0, 0, 32'd8000);
		push_cmd(0, -32'sd65536, 32'd20000);
		push_cmd(0, 0, 32'hFFFF_FFFF);
		push_cmd(0, 0, 0);
		push_cmd(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF);
		push_cmd(32'sh8000_0000, 32'sh8000_0000, 0);
		push_cmd(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		push_cmd(32'sh8000_0000, 0, 32'hFFFF_FFFF);
		push_cmd(0, 32'sh7FFF_FFFF, 32'h8000_0000);
		push_cmd(0, 32'sh8000_0000, 32'h8000_0000);
		push_cmd(0, 32'sh8000_0000, 32'h8000_0000);
		push_cmd(-32'sd65536, 32'sd1, 32'd1);
		gen_items(60);
		drain();

		cfg_all($urandom_range(1000, 20000), $urandom_range(5000, 60000),
			$urandom_range(65536, 8000000), $urandom_range(100, 30000),
			$urandom_range(50, 4000), $urandom_range(1000, 200000),
			$urandom_range(1000, 200000));
		gen_items(70);
		drain();

		// smallest register values
		cfg_all(1, 1, 1, 1, 1, 1, 1);
		gen_items(50);
		drain();

		// largest register values
		cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		gen_items(50);
		drain();

		// divisor registers at zero act as one lsb
		cfg_all(0, RST_WHEEL_BASE, RST_GEAR_RATIO, 0, RST_PWM_FULL, 0, 0);
		gen_items(40);
		drain();

		// no idling on either side
		gap_max = 0;
		stall_max = 0;
		cfg_all(RST_WHEEL_RADIUS, RST_WHEEL_BASE, RST_GEAR_RATIO, RST_MOTOR_MAX,
			RST_PWM_FULL, RST_ACCEL_TIME, RST_DECEL_TIME);
		gen_items(80);
		drain();

		gap_max = 18;
		stall_max = 18;
		cfg_all($urandom, $urandom, $urandom, $urandom_range(1, 65535),
			$urandom_range(1, 65535), $urandom, $urandom);
		gen_items(80);
		drain();

		$display("covered %0d command items and %0d drive results over seven register settings",
			n_sent, n_checked);
		$display("settings included minimum, maximum and zero divisor registers");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
